### rtl/core/gas_sensor_frame_parser_unit_defines.svh
// ---------------------------------------------------------------------------
// gas sensor frame parser assertion macros
// concurrent assertion forms used by the parser's result stage
// ---------------------------------------------------------------------------
`ifndef GAS_SENSOR_FRAME_PARSER_UNIT_DEFINES_SVH
`define GAS_SENSOR_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GSFP_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define GSFP_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/core/gsfp_pkg.sv
// ---------------------------------------------------------------------------
// gas sensor frame parser package
// frame constants, fault codes and the tracker to result-stage bundle
// ---------------------------------------------------------------------------
package gsfp_pkg;

    // byte values on the wire
    localparam logic [7:0] SYNC_BYTE = 8'hAC;
    localparam logic [7:0] TYPE_BYTE = 8'hAA;
    localparam logic [7:0] LEN_BYTE  = 8'd19;

    // sum of the two sync bytes that seeds the checksum
    localparam logic [7:0] SYNC_SUM = SYNC_BYTE + SYNC_BYTE;

    // byte positions inside the frame
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_HUNT     = 5'd0;
    localparam logic [POS_W-1:0] POS_SYNC2    = 5'd1;
    localparam logic [POS_W-1:0] POS_LEN      = 5'd2;
    localparam logic [POS_W-1:0] POS_TYPE     = 5'd3;
    localparam logic [POS_W-1:0] POS_PPM_LO   = 5'd10;
    localparam logic [POS_W-1:0] POS_STATUS   = 5'd13;
    localparam logic [POS_W-1:0] POS_CHECKSUM = 5'd18;
    localparam logic [POS_W-1:0] POS_END      = 5'd19;

    // fault codes reported with each frame
    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_HEADER   = 2'd1,
        FAULT_CHECKSUM = 2'd2
    } t_fault;

    // completed frame handed from tracker to result stage
    typedef struct packed {
        logic        done;
        t_fault      fault;
        logic [31:0] fields;
    } t_frame_done;

endpackage

### rtl/core/gas_sensor_frame_parser_unit.sv
// ---------------------------------------------------------------------------
// gas sensor frame parser unit
// byte-stream parser for the sensor's 19-byte measurement frame
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per request on i_rx_byte, qualified by
//   i_valid and held back by o_stall. Output channel: one result per
//   completed frame (after the checksum byte), qualified by o_valid and held
//   back by i_stall. Sync bytes and mid-frame bytes produce no result.
//   Throughput: one byte per clock while the result register is not blocked.
//   The parser state updates in a single pass between the input register
//   and the result register. The checksum byte passes through the input
//   register, then the result register, which raises o_valid.
//   The result carries the verdict, the held readings and both counters
//   as they stand after this frame.
//   When the receiver stalls, the result holds and one more byte can wait
//   in the input register; further bytes are stalled until the receiver
//   takes the result.
//   Reset (synchronous, active low) empties both registers, returns the
//   parser to sync hunt and clears the held readings and counters.
// ---------------------------------------------------------------------------
module gas_sensor_frame_parser_unit
    import gsfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_frame_good,
    output logic [1:0]  o_fault_kind,
    output logic [15:0] o_gas_ppm,
    output logic [7:0]  o_lel_percent,
    output logic [7:0]  o_device_status,
    output logic        o_reading_valid,
    output logic [31:0] o_good_frames,
    output logic [31:0] o_bad_frames
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        process;
    logic        accept;
    t_frame_done frame;

    // the waiting byte moves on unless the result register is blocked
    assign process = r_in_valid && !(o_valid && i_stall);
    assign o_stall = r_in_valid && !process;
    assign accept  = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    gsfp_frame_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (process),
        .i_byte  (r_in_byte),
        .o_frame (frame)
    );

    gsfp_result_stage u_result (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame         (frame),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_frame_good    (o_frame_good),
        .o_fault_kind    (o_fault_kind),
        .o_gas_ppm       (o_gas_ppm),
        .o_lel_percent   (o_lel_percent),
        .o_device_status (o_device_status),
        .o_reading_valid (o_reading_valid),
        .o_good_frames   (o_good_frames),
        .o_bad_frames    (o_bad_frames)
    );

endmodule

### rtl/core/gsfp_frame_tracker.sv
// ---------------------------------------------------------------------------
// gas sensor frame tracker
// sync hunt, byte position, running checksum, header check, field capture
// ---------------------------------------------------------------------------
module gsfp_frame_tracker
    import gsfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    output t_frame_done o_frame
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_sum;
    logic [7:0]       n_sum;
    logic             r_hdr_good;
    logic             n_hdr_good;
    logic [31:0]      r_fields;
    logic [31:0]      n_fields;
    logic [1:0]       lane;

    // byte lane of the captured reading fields
    assign lane = r_pos[1:0] - POS_PPM_LO[1:0];

    // per-byte state update
    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_hdr_good = r_hdr_good;
        n_fields   = r_fields;
        o_frame    = '{done: 1'b0, fault: FAULT_NONE, fields: r_fields};
        if (i_en) begin
            priority if (r_pos == POS_HUNT || r_pos >= POS_END) begin
                n_pos = (i_byte == SYNC_BYTE) ? POS_SYNC2 : POS_HUNT;
            end else if (r_pos == POS_SYNC2) begin
                if (i_byte == SYNC_BYTE) begin
                    n_pos      = POS_LEN;
                    n_sum      = SYNC_SUM;
                    n_hdr_good = 1'b1;
                    n_fields   = '0;
                end else begin
                    n_pos = POS_HUNT;
                end
            end else if (r_pos < POS_CHECKSUM) begin
                if (r_pos == POS_LEN && i_byte != LEN_BYTE) begin
                    n_hdr_good = 1'b0;
                end
                if (r_pos == POS_TYPE && i_byte != TYPE_BYTE) begin
                    n_hdr_good = 1'b0;
                end
                if (r_pos >= POS_PPM_LO && r_pos <= POS_STATUS) begin
                    n_fields[{lane, 3'b000} +: 8] = i_byte;
                end
                n_sum = r_sum + i_byte;
                n_pos = r_pos + 5'd1;
            end else begin
                // checksum byte closes the frame
                n_pos        = POS_HUNT;
                o_frame.done = 1'b1;
                priority if (!r_hdr_good) begin
                    o_frame.fault = FAULT_HEADER;
                end else if (r_sum != i_byte) begin
                    o_frame.fault = FAULT_CHECKSUM;
                end else begin
                    o_frame.fault = FAULT_NONE;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_HUNT;
            r_sum      <= '0;
            r_hdr_good <= 1'b1;
            r_fields   <= '0;
        end else begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_hdr_good <= n_hdr_good;
            r_fields   <= n_fields;
        end
    end

endmodule

### rtl/core/gsfp_result_stage.sv
// ---------------------------------------------------------------------------
// gas sensor result stage
// held readings, frame counters and the result register toward the receiver
// ---------------------------------------------------------------------------
`include "gas_sensor_frame_parser_unit_defines.svh"

module gsfp_result_stage
    import gsfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame_done i_frame,
    input  logic        i_stall,
    output logic        o_valid,
    output logic        o_frame_good,
    output logic [1:0]  o_fault_kind,
    output logic [15:0] o_gas_ppm,
    output logic [7:0]  o_lel_percent,
    output logic [7:0]  o_device_status,
    output logic        o_reading_valid,
    output logic [31:0] o_good_frames,
    output logic [31:0] o_bad_frames
);

    logic        r_valid;
    logic        r_good;
    t_fault      r_fault;
    logic [15:0] r_ppm;
    logic [7:0]  r_lel;
    logic [7:0]  r_status;
    logic        r_seen;
    logic [31:0] r_good_count;
    logic [31:0] r_bad_count;
    logic        frame_ok;

    assign frame_ok = i_frame.fault == FAULT_NONE;

    // result valid flag and verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_frame.done) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.done) begin
            r_good  <= frame_ok;
            r_fault <= i_frame.fault;
        end
    end

    // held readings and counters, frozen while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppm        <= '0;
            r_lel        <= '0;
            r_status     <= '0;
            r_seen       <= 1'b0;
            r_good_count <= '0;
            r_bad_count  <= '0;
        end else if (i_frame.done) begin
            if (frame_ok) begin
                r_ppm        <= i_frame.fields[15:0];
                r_lel        <= i_frame.fields[23:16];
                r_status     <= i_frame.fields[31:24];
                r_seen       <= 1'b1;
                r_good_count <= r_good_count + 32'd1;
            end else begin
                r_bad_count  <= r_bad_count + 32'd1;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_frame_good    = r_good;
    assign o_fault_kind    = r_fault;
    assign o_gas_ppm       = r_ppm;
    assign o_lel_percent   = r_lel;
    assign o_device_status = r_status;
    assign o_reading_valid = r_seen;
    assign o_good_frames   = r_good_count;
    assign o_bad_frames    = r_bad_count;

    // checks
    `GSFP_ASSERT_NOW(a_good_matches_fault, i_clk, i_rst_n, r_valid,
        r_good == (r_fault == FAULT_NONE), "frame_good disagrees with fault_kind")
    `GSFP_ASSERT_NOW(a_good_sets_seen, i_clk, i_rst_n, r_valid && r_good,
        r_seen, "good frame reported without reading_valid")
    `GSFP_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, r_valid && i_stall,
        !i_frame.done, "new frame while stalled result pending")
    `GSFP_ASSERT_NEXT(a_good_count_step, i_clk, i_rst_n, i_frame.done && frame_ok,
        r_good_count == $past(r_good_count) + 32'd1, "good counter missed a step")
    `GSFP_ASSERT_NEXT(a_counts_idle, i_clk, i_rst_n, !i_frame.done,
        $stable(r_good_count) && $stable(r_bad_count), "counter moved without frame")

endmodule
